// ----- sv/bnp_pkg.sv -----
// Shared types, constants and helpers for the blocked next-permutation unit.
// Used by every module of the block and by its checker; no dependencies.
package bnp_pkg;

  localparam int MAX_POSITIONS = 16;
  localparam int EFF_CAP       = (MAX_POSITIONS < 16) ? MAX_POSITIONS : 16;
  localparam int ADDR_W        = $clog2(MAX_POSITIONS);
  localparam int IDX_W         = $clog2(EFF_CAP);
  localparam int ELEM_W        = 4;
  localparam int POS_W         = 4;
  localparam int LEN_W         = 5;
  localparam int MASK_W        = 16;
  localparam int CFG_ADDR_W    = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_PERM_LENGTH    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_END_MASK = 1'b1;

  // Opcodes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [LEN_W-1:0]  PERM_LENGTH_RST = LEN_W'(16);
  localparam logic [MASK_W-1:0] BLOCK_MASK_RST  = MASK_W'(32768);

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Memory port request: one read, one write per cycle
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    elem_t wr_data;
  } mem_req_t;

  // Settings the sequencer works from
  typedef struct packed {
    idx_t              n_last;
    logic [MASK_W-1:0] mask;
  } cfg_t;

  // Element stream from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] position;
    elem_t            element;
    logic             advanced;
    logic             last;
  } emit_t;

  // Index of the last position in use, from the raw length register
  function automatic idx_t eff_last(input logic [LEN_W-1:0] plen);
    logic [LEN_W-1:0] len;
    len = plen;
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if (32'(len) > EFF_CAP) begin
      len = LEN_W'(EFF_CAP);
    end
    return IDX_W'(len - LEN_W'(1));
  endfunction

endpackage

// ----- sv/blocked_next_permutation_unit.sv -----
// Sequence: a load is written as it is accepted. An advance is accepted, then each block
// of positions is pivot-scanned; an exhausted block is cleared to identity and the next
// block scanned; then come the pivot swap, a read/read/write/write swap per reversed pair,
// and the n results are streamed out through the one store read port.
// Throughput: one item at a time; no new item is taken until an advance has streamed out.
// Reset: store reads as identity, perm_length 16, block_end_mask 0x8000.
//
// Top level of the blocked next-permutation unit: configuration registers,
// output register, sequencer and store. Depends on bnp_pkg, bnp_mem, bnp_seq.
module blocked_next_permutation_unit (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [bnp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bnp_pkg::MASK_W-1:0]     cfg_wdata,
  // item channel
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           opcode,
  input  logic [bnp_pkg::POS_W-1:0]      position,
  input  logic [bnp_pkg::ELEM_W-1:0]     element,
  // result channel
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [bnp_pkg::POS_W-1:0]      out_position,
  output logic [bnp_pkg::ELEM_W-1:0]     out_element,
  output logic                           advanced,
  output logic                           last
);

  logic [bnp_pkg::LEN_W-1:0]  perm_length;
  logic [bnp_pkg::MASK_W-1:0] block_end_mask;

  bnp_pkg::cfg_t     cfg;
  bnp_pkg::mem_req_t req;
  bnp_pkg::elem_t    rdata;
  bnp_pkg::emit_t    em;
  logic              em_ready;

  // Config registers; the user must write them only while the unit is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length    <= bnp_pkg::PERM_LENGTH_RST;
      block_end_mask <= bnp_pkg::BLOCK_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bnp_pkg::CFG_PERM_LENGTH:    perm_length    <= cfg_wdata[bnp_pkg::LEN_W-1:0];
        bnp_pkg::CFG_BLOCK_END_MASK: block_end_mask <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Length 0 counts as 1, oversized lengths saturate. Mask bits above n-1 are
  // never looked at since the scan stops at n-1.
  assign cfg.n_last = bnp_pkg::eff_last(perm_length);
  assign cfg.mask   = block_end_mask;

  bnp_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .opcode     (opcode),
    .position   (position),
    .element    (element),
    .cfg        (cfg),
    .req        (req),
    .rdata      (rdata),
    .em         (em),
    .em_ready   (em_ready)
  );

  bnp_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

  // Output register: takes a new element whenever it is empty or its
  // current transfer completes this cycle.
  assign em_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (em_ready) begin
      result_valid <= em.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (em_ready && em.valid) begin
      out_position <= em.position;
      out_element  <= em.element;
      advanced     <= em.advanced;
      last         <= em.last;
    end
  end

endmodule

// ----- sv/bnp_mem.sv -----
// Permutation store: synchronous memory, one read and one write port,
// registered read data. Entries never written read as their own index.
// Depends on bnp_pkg.
module bnp_mem (
  input  logic              clk,
  input  logic              rst,
  input  bnp_pkg::mem_req_t req,
  output bnp_pkg::elem_t    rdata
);

  bnp_pkg::elem_t                     mem [bnp_pkg::MAX_POSITIONS];
  logic [bnp_pkg::MAX_POSITIONS-1:0]  vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // identity on reset: entry valid once written
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= vld[req.rd_addr] ? mem[req.rd_addr] : bnp_pkg::ELEM_W'(req.rd_addr);
    end
  end

endmodule

// ----- sv/bnp_seq.sv -----
// Sequencer: takes items, runs the block scan / swap / reverse / clear over
// the store and streams the permutation out. Depends on bnp_pkg.
module bnp_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic                      opcode,
  input  logic [bnp_pkg::POS_W-1:0] position,
  input  bnp_pkg::elem_t            element,
  input  bnp_pkg::cfg_t             cfg,
  output bnp_pkg::mem_req_t         req,
  input  bnp_pkg::elem_t            rdata,
  output bnp_pkg::emit_t            em,
  input  logic                      em_ready
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_ISSUE, S_SCAN, S_SWAP_P, S_SWAP_Q,
    S_REV_A, S_REV_B, S_REV_C, S_REV_D, S_CLEAR, S_EMIT
  } state_t;

  localparam int XW = bnp_pkg::IDX_W + 1;

  state_t          state;
  bnp_pkg::idx_t   k, start_k, blk_end, piv, part, lo, hi, pend_k;
  bnp_pkg::elem_t  prev_val, piv_val, part_val, lo_val;
  logic            scan_first, piv_found, adv, rd_pend, issue_done;

  logic            accept, new_piv, found_now, at_end, issue, wr_ok;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign wr_ok      = 32'(position) < bnp_pkg::MAX_POSITIONS;
  assign new_piv    = !scan_first && (prev_val < rdata);
  assign found_now  = piv_found || new_piv;
  assign at_end     = (k == cfg.n_last) || cfg.mask[k];
  assign issue      = (state == S_EMIT) && !issue_done && (!rd_pend || em_ready);

  always_comb begin
    req = '0;
    case (state)
      S_IDLE: begin
        req.wr_en   = accept && (opcode == bnp_pkg::OP_LOAD) && wr_ok;
        req.wr_addr = bnp_pkg::ADDR_W'(position);
        req.wr_data = element;
      end
      S_SCAN_ISSUE: begin
        req.rd_en   = 1'b1;
        req.rd_addr = bnp_pkg::ADDR_W'(start_k);
      end
      S_SCAN: begin
        req.rd_en   = !at_end;
        req.rd_addr = bnp_pkg::ADDR_W'(k + 1'b1);
      end
      S_SWAP_P: begin
        req.wr_en   = 1'b1;
        req.wr_addr = bnp_pkg::ADDR_W'(piv);
        req.wr_data = part_val;
      end
      S_SWAP_Q: begin
        req.wr_en   = 1'b1;
        req.wr_addr = bnp_pkg::ADDR_W'(part);
        req.wr_data = piv_val;
      end
      S_REV_A: begin
        req.rd_en   = 1'b1;
        req.rd_addr = bnp_pkg::ADDR_W'(lo);
      end
      S_REV_B: begin
        req.rd_en   = 1'b1;
        req.rd_addr = bnp_pkg::ADDR_W'(hi);
      end
      S_REV_C: begin
        req.wr_en   = 1'b1;
        req.wr_addr = bnp_pkg::ADDR_W'(lo);
        req.wr_data = rdata;
      end
      S_REV_D: begin
        req.wr_en   = 1'b1;
        req.wr_addr = bnp_pkg::ADDR_W'(hi);
        req.wr_data = lo_val;
      end
      S_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = bnp_pkg::ADDR_W'(k);
        req.wr_data = bnp_pkg::ELEM_W'(k);
      end
      S_EMIT: begin
        req.rd_en   = issue;
        req.rd_addr = bnp_pkg::ADDR_W'(k);
      end
      default: req = '0;
    endcase
  end

  assign em.valid    = rd_pend;
  assign em.position = bnp_pkg::POS_W'(pend_k);
  assign em.element  = rdata;
  assign em.advanced = adv;
  assign em.last     = (pend_k == cfg.n_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pend    <= 1'b0;
      issue_done <= 1'b0;
      scan_first <= 1'b0;
      piv_found  <= 1'b0;
      adv        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (opcode == bnp_pkg::OP_ADVANCE)) begin
            start_k <= '0;
            state   <= S_SCAN_ISSUE;
          end
        end
        S_SCAN_ISSUE: begin
          k          <= start_k;
          scan_first <= 1'b1;
          piv_found  <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          // rdata holds the element at k
          if (new_piv) begin
            piv_found <= 1'b1;
            piv       <= k - 1'b1;
            piv_val   <= prev_val;
            part      <= k;
            part_val  <= rdata;
          end else if (piv_found && (rdata > piv_val)) begin
            part     <= k;
            part_val <= rdata;
          end
          prev_val   <= rdata;
          scan_first <= 1'b0;
          if (!at_end) begin
            k <= k + 1'b1;
          end else begin
            blk_end <= k;
            if (found_now) begin
              state <= S_SWAP_P;
            end else begin
              k     <= start_k;
              state <= S_CLEAR;
            end
          end
        end
        S_SWAP_P: begin
          state <= S_SWAP_Q;
        end
        S_SWAP_Q: begin
          lo <= piv + 1'b1;
          hi <= blk_end;
          if ((XW'(piv) + XW'(1)) < XW'(blk_end)) begin
            state <= S_REV_A;
          end else begin
            adv        <= 1'b1;
            k          <= '0;
            issue_done <= 1'b0;
            state      <= S_EMIT;
          end
        end
        S_REV_A: begin
          state <= S_REV_B;
        end
        S_REV_B: begin
          lo_val <= rdata;
          state  <= S_REV_C;
        end
        S_REV_C: begin
          state <= S_REV_D;
        end
        S_REV_D: begin
          lo <= lo + 1'b1;
          hi <= hi - 1'b1;
          if ((XW'(lo) + XW'(2)) < XW'(hi)) begin
            state <= S_REV_A;
          end else begin
            adv        <= 1'b1;
            k          <= '0;
            issue_done <= 1'b0;
            state      <= S_EMIT;
          end
        end
        S_CLEAR: begin
          if (k == blk_end) begin
            if (blk_end == cfg.n_last) begin
              adv        <= 1'b0;
              k          <= '0;
              issue_done <= 1'b0;
              state      <= S_EMIT;
            end else begin
              start_k <= k + 1'b1;
              state   <= S_SCAN_ISSUE;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_EMIT: begin
          if (issue) begin
            pend_k  <= k;
            rd_pend <= 1'b1;
            if (k == cfg.n_last) begin
              issue_done <= 1'b1;
            end else begin
              k <= k + 1'b1;
            end
          end else if (em_ready) begin
            rd_pend <= 1'b0;
          end
          if (issue_done && (!rd_pend || em_ready)) begin
            rd_pend <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/bnp_checker.sv -----
// Port-level checks for the blocked next-permutation unit, bound to the top.
// Depends on bnp_pkg.
module bnp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic [bnp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [bnp_pkg::MASK_W-1:0]     cfg_wdata,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [bnp_pkg::POS_W-1:0]      out_position,
  input logic [bnp_pkg::ELEM_W-1:0]     out_element,
  input logic                           advanced,
  input logic                           last
);

  logic [bnp_pkg::LEN_W-1:0] plen;
  logic [bnp_pkg::POS_W-1:0] exp_pos;
  logic                      in_burst, burst_adv;
  logic                      res_xfer;

  assign res_xfer = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plen     <= bnp_pkg::PERM_LENGTH_RST;
      exp_pos  <= '0;
      in_burst <= 1'b0;
    end else begin
      if (cfg_we && (cfg_addr == bnp_pkg::CFG_PERM_LENGTH)) begin
        plen <= cfg_wdata[bnp_pkg::LEN_W-1:0];
      end
      if (res_xfer) begin
        exp_pos  <= last ? '0 : out_position + 1'b1;
        in_burst <= !last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_xfer) begin
      burst_adv <= advanced;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_position)
      && $stable(out_element) && $stable(advanced) && $stable(last))
    else $error("stalled result changed");

  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> out_position == exp_pos)
    else $error("result position out of order");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && in_burst |-> advanced == burst_adv)
    else $error("advanced flag changed within a burst");

  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> last == (out_position == bnp_pkg::POS_W'(bnp_pkg::eff_last(plen))))
    else $error("last flag does not match length");

endmodule

bind blocked_next_permutation_unit bnp_checker u_bnp_checker (.*);

// ----- bench/blocked_next_permutation_unit_tb.sv -----
// Self-checking bench for blocked_next_permutation_unit: a queue-fed driver, a monitor and an
// in-bench predictor of the blocked odometer permutation step. Depends on bnp_pkg and the RTL.
`timescale 1ns / 100ps

module blocked_next_permutation_unit_tb;

  localparam int CAP            = (bnp_pkg::MAX_POSITIONS < 16) ? bnp_pkg::MAX_POSITIONS : 16;
  localparam int SETTLE_CYCLES  = 200;    // covers the longest advance with margin
  localparam int WATCHDOG_LIMIT = 20000;  // cycles without any transfer
  localparam int CFG_PAD_W      = bnp_pkg::MASK_W - bnp_pkg::LEN_W;

  typedef struct {
    logic                       op;
    logic [bnp_pkg::POS_W-1:0]  pos;
    logic [bnp_pkg::ELEM_W-1:0] elem;
  } item_t;

  typedef struct {
    logic [bnp_pkg::POS_W-1:0]  pos;
    logic [bnp_pkg::ELEM_W-1:0] elem;
    logic                       adv;
    logic                       last;
  } result_t;

  logic                           clk        = 1'b0;
  logic                           rst        = 1'b1;
  logic                           cfg_we     = 1'b0;
  logic [bnp_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [bnp_pkg::MASK_W-1:0]     cfg_wdata  = '0;
  logic                           item_valid = 1'b0;
  logic                           item_ready;
  logic                           opcode     = bnp_pkg::OP_LOAD;
  logic [bnp_pkg::POS_W-1:0]      position   = '0;
  logic [bnp_pkg::ELEM_W-1:0]     element    = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  logic [bnp_pkg::POS_W-1:0]      out_position;
  logic [bnp_pkg::ELEM_W-1:0]     out_element;
  logic                           advanced;
  logic                           last;

  // Predictor state: its own copy of the store and of both registers
  bnp_pkg::elem_t             perm_copy [bnp_pkg::MAX_POSITIONS];
  logic [bnp_pkg::LEN_W-1:0]  len_copy  = bnp_pkg::PERM_LENGTH_RST;
  logic [bnp_pkg::MASK_W-1:0] mask_copy = bnp_pkg::BLOCK_MASK_RST;

  item_t   item_backlog [$];   // items waiting for the driver
  result_t due_results  [$];   // predicted results, oldest first
  item_t   cur_item;
  result_t want;

  int items_queued   = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int errors         = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  blocked_next_permutation_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .opcode       (opcode),
    .position     (position),
    .element      (element),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_position (out_position),
    .out_element  (out_element),
    .advanced     (advanced),
    .last         (last)
  );

  always #5 clk = ~clk;

  initial begin
    for (int k = 0; k < bnp_pkg::MAX_POSITIONS; k++) begin
      perm_copy[k] = bnp_pkg::elem_t'(k);
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Positions in use: zero counts as one, anything past the store saturates
  function automatic int span_of(logic [bnp_pkg::LEN_W-1:0] raw);
    int n;
    n = int'(raw);
    if (n == 0) begin
      n = 1;
    end
    if (n > CAP) begin
      n = CAP;
    end
    return n;
  endfunction

  // Odometer step over the blocks; returns 0 when every block wrapped to identity
  function automatic bit next_arrangement(int n);
    int             start;
    int             stop;
    int             piv;
    int             mate;
    int             lo;
    int             hi;
    bnp_pkg::elem_t t;
    start = 0;
    while (start < n) begin
      stop = start;
      while (stop < n - 1 && !mask_copy[stop]) begin
        stop++;
      end
      piv = -1;
      for (int i = start; i < stop; i++) begin
        if (perm_copy[i] < perm_copy[i+1]) begin
          piv = i;
        end
      end
      if (piv >= 0) begin
        mate = piv + 1;
        for (int j = piv + 1; j <= stop; j++) begin
          if (perm_copy[piv] < perm_copy[j]) begin
            mate = j;
          end
        end
        t               = perm_copy[piv];
        perm_copy[piv]  = perm_copy[mate];
        perm_copy[mate] = t;
        lo = piv + 1;
        hi = stop;
        while (lo < hi) begin
          t             = perm_copy[lo];
          perm_copy[lo] = perm_copy[hi];
          perm_copy[hi] = t;
          lo++;
          hi--;
        end
        return 1'b1;
      end
      // exhausted block goes back to identity before the next one is tried
      for (int i = start; i <= stop; i++) begin
        perm_copy[i] = bnp_pkg::elem_t'(i);
      end
      start = stop + 1;
    end
    return 1'b0;
  endfunction

  // Applies one accepted item to the copy and queues what it must produce
  task automatic predict_item(item_t it);
    int      n;
    bit      stepped;
    result_t r;
    if (it.op == bnp_pkg::OP_LOAD) begin
      if (int'(it.pos) < bnp_pkg::MAX_POSITIONS) begin
        perm_copy[it.pos] = it.elem;
      end
    end else begin
      n       = span_of(len_copy);
      stepped = next_arrangement(n);
      for (int k = 0; k < n; k++) begin
        r.pos  = bnp_pkg::POS_W'(k);
        r.elem = perm_copy[k];
        r.adv  = stepped;
        r.last = (k == n - 1);
        due_results.push_back(r);
      end
    end
  endtask

  task automatic report_error(string what, int got, int exp_val);
    $display("error: result %0d %s got %0h wanted %0h at %0t",
             results_seen, what, got, exp_val, $realtime);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: holds valid and payload until the transfer, then maybe idles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) begin
        predict_item(cur_item);
        items_accepted++;
      end
      if (!item_valid || item_ready) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item   = item_backlog.pop_front();
          item_valid <= 1'b1;
          opcode     <= cur_item.op;
          position   <= cur_item.pos;
          element    <= cur_item.elem;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          report_error("unexpected", int'(out_position), 0);
        end else begin
          want = due_results.pop_front();
          if (out_position !== want.pos) begin
            report_error("out_position", int'(out_position), int'(want.pos));
          end
          if (out_element !== want.elem) begin
            report_error("out_element", int'(out_element), int'(want.elem));
          end
          if (advanced !== want.adv) begin
            report_error("advanced", int'(advanced), int'(want.adv));
          end
          if (last !== want.last) begin
            report_error("last", int'(last), int'(want.last));
          end
        end
        results_seen++;
      end
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run with no transfer for too long is hung
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_item(logic op, int pos, int elem);
    item_t it;
    it.op   = op;
    it.pos  = bnp_pkg::POS_W'(pos);
    it.elem = bnp_pkg::ELEM_W'(elem);
    item_backlog.push_back(it);
    items_queued++;
  endtask

  // Wait until every item went in and every result came out, then let the
  // block finish any trailing work (a load leaves nothing to wait on)
  task automatic settle();
    while (items_accepted != items_queued || due_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Both registers, one per cycle, only while the block is idle
  task automatic set_config(logic [bnp_pkg::LEN_W-1:0] len, logic [bnp_pkg::MASK_W-1:0] mask);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= bnp_pkg::CFG_PERM_LENGTH;
    // upper bits are don't-care
    cfg_wdata <= {CFG_PAD_W'($urandom), len};
    len_copy  = len;
    @(posedge clk);
    cfg_addr  <= bnp_pkg::CFG_BLOCK_END_MASK;
    cfg_wdata <= mask;
    mask_copy = mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Full load of the positions in use followed by a run of advances
  task automatic add_sequence();
    int vals [16];
    int n;
    int j;
    int t;
    int style;
    int order [16];
    n     = span_of(len_copy);
    style = $urandom_range(3);
    for (int i = 0; i < 16; i++) begin
      vals[i]  = i;
      order[i] = i;
    end
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      t       = vals[i];
      vals[i] = vals[j];
      vals[j] = t;
    end
    for (int i = 0; i < n; i++) begin
      case (style)
        1: begin
          vals[i] = $urandom_range(15);          // repeats allowed
        end
        2: begin
          vals[i] = n - 1 - i;                   // last order of one block
        end
        3: begin
          vals[i] = (i >= n - 2) ? i - n + 2 + n - 2 - (i - (n - 2)) * 0 : n - 1 - i;
        end
        default: begin
        end
      endcase
    end
    if (style == 3 && n >= 2) begin
      // descending except the tail pair: one step from the end
      vals[n-2] = 0;
      vals[n-1] = 1;
    end
    // write order is shuffled half of the time
    if ($urandom_range(1) == 1) begin
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        t        = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    for (int i = 0; i < n; i++) begin
      add_item(bnp_pkg::OP_LOAD, order[i], vals[order[i]]);
    end
    repeat ($urandom_range(1, 6)) begin
      add_item(bnp_pkg::OP_ADVANCE, $urandom_range(15), $urandom_range(15));
    end
  endtask

  task automatic add_phase(int target);
    int first;
    first = items_queued;
    while (items_queued - first < target) begin
      if ($urandom_range(99) < 78) begin
        add_sequence();
      end else if ($urandom_range(1) == 0) begin
        add_item(bnp_pkg::OP_LOAD, $urandom_range(15), $urandom_range(15));   // stray load
      end else begin
        add_item(bnp_pkg::OP_ADVANCE, $urandom_range(15), $urandom_range(15));
      end
    end
  endtask

  initial begin
    logic [bnp_pkg::LEN_W-1:0]  len_tab  [12];
    logic [bnp_pkg::MASK_W-1:0] mask_tab [12];
    logic [bnp_pkg::MASK_W-1:0] mask;

    len_tab  = '{5'd16, 5'd4,  5'd1,  5'd31, 5'd7,  5'd0,
                 5'd16, 5'd12, 5'd5,  5'd16, 5'd3,  5'd9};
    mask_tab = '{16'h8000, 16'h0005, 16'hFFFF, 16'h0000, 16'h0024, 16'h1234,
                 16'h0000, 16'hFFFF, 16'h0000, 16'h00FF, 16'h0000, 16'h0000};

    send_idle_pct = 14;
    recv_idle_pct = 81;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, identity start, field extremes
    add_item(bnp_pkg::OP_ADVANCE, 0, 0);
    add_item(bnp_pkg::OP_LOAD, 0, 15);
    add_item(bnp_pkg::OP_LOAD, 15, 0);
    add_item(bnp_pkg::OP_ADVANCE, 15, 15);
    // one block of three in last order wraps, then steps again
    set_config(5'd3, 16'h0000);
    add_item(bnp_pkg::OP_LOAD, 0, 2);
    add_item(bnp_pkg::OP_LOAD, 1, 1);
    add_item(bnp_pkg::OP_LOAD, 2, 0);
    add_item(bnp_pkg::OP_ADVANCE, 0, 0);
    add_item(bnp_pkg::OP_ADVANCE, 0, 0);
    // repeated values: no strict pivot, so the block wraps
    add_item(bnp_pkg::OP_LOAD, 0, 5);
    add_item(bnp_pkg::OP_LOAD, 1, 5);
    add_item(bnp_pkg::OP_LOAD, 2, 5);
    add_item(bnp_pkg::OP_ADVANCE, 0, 0);
    // length zero runs as one position
    set_config(5'd0, 16'hFFFF);
    add_item(bnp_pkg::OP_ADVANCE, 0, 0);
    // oversized length saturates to the store size
    set_config(5'd31, 16'h0101);
    add_item(bnp_pkg::OP_ADVANCE, 0, 0);
    // every block one position wide: always wraps
    set_config(5'd4, 16'hFFFF);
    add_item(bnp_pkg::OP_ADVANCE, 0, 0);

    // Random phases: four settings per idling regime
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        settle();
        send_idle_pct = 81;
        recv_idle_pct = 14;
      end else if (ph == 8) begin
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mask = mask_tab[ph];
      if (ph >= 6 && ph % 2 == 0) begin
        mask = bnp_pkg::MASK_W'($urandom);
      end
      set_config(len_tab[ph], mask);
      add_phase(32);
    end

    settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- blocked_next_permutation_unit.f -----
sv/bnp_pkg.sv
sv/bnp_mem.sv
sv/bnp_seq.sv
sv/blocked_next_permutation_unit.sv
sv/bnp_checker.sv
bench/blocked_next_permutation_unit_tb.sv
